// ----- rtl/nkct_pkg.sv -----
// Shared types and constants for the name-keyed contact table.
// Used by nkct_ctrl, nkct_datapath and the top level; no dependencies.
package nkct_pkg;

	// Widest text held: 19 characters of 8 bits
	localparam int unsigned TEXT_MAX_W = 152;

	// Packed text "removed", first character in the lowest byte
	localparam logic [TEXT_MAX_W-1:0] REMOVED_TEXT = 152'h0064_6576_6F6D_6572;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_MATCH = 2'd0,
		STAT_DONE  = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture key, number and mode; clear scan index
		logic insert;   // append entry (or refuse) and post the single result
		logic scan;     // read entry at scan index, advance index
		logic finish;   // post the closing done result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;    // no entries stored
		logic scan_end; // scan index points at the last stored entry
	} sts_t;

endpackage

// ----- rtl/nkct_ctrl.sv -----
// Sequencer for the name-keyed contact table: one-hot state machine.
// Depends on nkct_pkg (cmd_t, sts_t, mode codes).
module nkct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  nkct_pkg::sts_t   sts,
	output nkct_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_INSERT = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_nx;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == nkct_pkg::MODE_INSERT) begin
						state_nx = S_INSERT;
					end else if ((mode == nkct_pkg::MODE_SEARCH ||
						mode == nkct_pkg::MODE_DELETE) && !sts.empty) begin
						state_nx = S_SCAN;
					end else begin
						state_nx = S_FINISH;
					end
				end
			end
			S_INSERT: state_nx = S_IDLE;
			S_SCAN: begin
				if (sts.scan_end) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN:  state_nx = S_FINISH;
			S_FINISH: state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Commands
	always_comb begin
		cmd.load   = accept;
		cmd.insert = (state_q == S_INSERT);
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FINISH);
	end

endmodule

// ----- rtl/nkct_datapath.sv -----
// Datapath of the name-keyed contact table: entry memories, entry count,
// scan index, compare stage and result register. Depends on nkct_pkg.
module nkct_datapath #(
	parameter int unsigned ENTRIES    = 32,
	parameter int unsigned TEXT_BYTES = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nkct_pkg::cmd_t   cmd,
	output nkct_pkg::sts_t   sts,
	input  logic [1:0]       mode,
	input  logic [63:0]      name_low,
	input  logic [63:0]      name_mid,
	input  logic [23:0]      name_high,
	input  logic [63:0]      number_low,
	input  logic [63:0]      number_mid,
	input  logic [23:0]      number_high,
	output logic             valid,
	output logic [1:0]       status,
	output logic [63:0]      found_low,
	output logic [63:0]      found_mid,
	output logic [23:0]      found_high,
	output logic             last
);

	localparam int unsigned TEXT_W = 8 * TEXT_BYTES;
	localparam int unsigned AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW     = $clog2(ENTRIES + 1);

	localparam logic [TEXT_W-1:0] REMOVED_W = nkct_pkg::REMOVED_TEXT[TEXT_W-1:0];

	// Entry memories
	logic [TEXT_W-1:0] name_mem [ENTRIES];
	logic [TEXT_W-1:0] num_mem  [ENTRIES];

	logic [TEXT_W-1:0] key_q, num_q;
	logic [1:0]        mode_q;
	logic [CW-1:0]     entry_count_q, idx_q;
	logic [AW-1:0]     idx_s1;
	logic              cmp_vld_s1;
	logic [TEXT_W-1:0] rd_name_s1, rd_num_s1;

	logic              full, match;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [TEXT_W-1:0] wr_name, wr_num;
	logic [nkct_pkg::TEXT_MAX_W-1:0] key_in, num_in, found_ext;

	logic              out_vld_q, last_q;
	logic [1:0]        status_q;
	logic [TEXT_W-1:0] found_q;

	assign key_in = {name_high, name_mid, name_low};
	assign num_in = {number_high, number_mid, number_low};

	// Captured beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key_in[TEXT_W-1:0];
			num_q  <= num_in[TEXT_W-1:0];
			mode_q <= mode;
		end
	end

	assign full = (entry_count_q == CW'(ENTRIES));

	// Entry count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			idx_q         <= '0;
			cmp_vld_s1    <= 1'b0;
		end else begin
			if (cmd.insert && !full) begin
				entry_count_q <= entry_count_q + CW'(1);
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + CW'(1);
			end
			cmp_vld_s1 <= cmd.scan;
		end
	end

	assign sts.empty    = (entry_count_q == '0);
	assign sts.scan_end = ((idx_q + CW'(1)) == entry_count_q);

	// Compare stage on the registered read data
	assign match = cmp_vld_s1 && (rd_name_s1 == key_q);

	// Single write port: append on an insert to a table that is not full, overwrite on delete match
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_name = REMOVED_W;
		wr_num  = REMOVED_W;
		if (cmd.insert && !full) begin
			wr_en   = 1'b1;
			wr_addr = entry_count_q[AW-1:0];
			wr_name = key_q;
			wr_num  = num_q;
		end else if (match && mode_q == nkct_pkg::MODE_DELETE) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_mem[wr_addr] <= wr_name;
			num_mem[wr_addr]  <= wr_num;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_name_s1 <= name_mem[idx_q[AW-1:0]];
			rd_num_s1  <= num_mem[idx_q[AW-1:0]];
			idx_s1     <= idx_q[AW-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			last_q    <= 1'b0;
			status_q  <= nkct_pkg::STAT_DONE;
			found_q   <= '0;
		end else begin
			out_vld_q <= 1'b0;
			if (cmd.insert) begin
				out_vld_q <= 1'b1;
				last_q    <= 1'b1;
				status_q  <= full ? nkct_pkg::STAT_FULL : nkct_pkg::STAT_DONE;
				found_q   <= '0;
			end else if (cmd.finish) begin
				out_vld_q <= 1'b1;
				last_q    <= 1'b1;
				status_q  <= nkct_pkg::STAT_DONE;
				found_q   <= '0;
			end else if (match && mode_q == nkct_pkg::MODE_SEARCH) begin
				out_vld_q <= 1'b1;
				last_q    <= 1'b0;
				status_q  <= nkct_pkg::STAT_MATCH;
				found_q   <= rd_num_s1;
			end
		end
	end

	assign found_ext  = nkct_pkg::TEXT_MAX_W'(found_q);
	assign valid      = out_vld_q;
	assign status     = status_q;
	assign last       = last_q;
	assign found_low  = found_ext[63:0];
	assign found_mid  = found_ext[127:64];
	assign found_high = found_ext[151:128];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(ENTRIES))
		else $error("entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q != $past(entry_count_q)) |->
		(entry_count_q == $past(entry_count_q) + CW'(1)) && $past(cmd.insert))
		else $error("entry count changed other than by an insert");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (idx_q < entry_count_q))
		else $error("scan read beyond stored entries");

	a_match_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q == nkct_pkg::STAT_MATCH) |-> !last_q)
		else $error("match beat flagged last");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.insert, cmd.finish, match && mode_q == nkct_pkg::MODE_SEARCH}))
		else $error("two result sources in one cycle");
`endif

endmodule

// ----- rtl/name_keyed_contact_table.sv -----
// Contact table of name/number entries kept in insertion order. A command is
// taken when start is high and busy is low; busy stays high until the block
// can take the next one. Results come out one beat per valid pulse and cannot
// be held off. An insert gives its one result through the insert state and the
// result register. A search or delete scans the stored entries through one
// memory read port, one entry per cycle, so its done beat follows the scan,
// drain and finish states (finish alone on an empty table); search match beats
// precede it in insertion order. Any other mode answers done via the finish state.
// Top level; depends on nkct_pkg, nkct_ctrl and nkct_datapath.
module name_keyed_contact_table #(
	parameter int unsigned ENTRIES    = 32,
	parameter int unsigned TEXT_BYTES = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [63:0] name_low,
	input  logic [63:0] name_mid,
	input  logic [23:0] name_high,
	input  logic [63:0] number_low,
	input  logic [63:0] number_mid,
	input  logic [23:0] number_high,
	output logic        valid,
	output logic [1:0]  status,
	output logic [63:0] found_low,
	output logic [63:0] found_mid,
	output logic [23:0] found_high,
	output logic        last
);

	nkct_pkg::cmd_t cmd;
	nkct_pkg::sts_t sts;

	nkct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	nkct_datapath #(
		.ENTRIES    (ENTRIES),
		.TEXT_BYTES (TEXT_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.name_low    (name_low),
		.name_mid    (name_mid),
		.name_high   (name_high),
		.number_low  (number_low),
		.number_mid  (number_mid),
		.number_high (number_high),
		.valid       (valid),
		.status      (status),
		.found_low   (found_low),
		.found_mid   (found_mid),
		.found_high  (found_high),
		.last        (last)
	);

endmodule

// ----- sim/name_keyed_contact_table_tb.sv -----
// Self-checking testbench for name_keyed_contact_table: directed and random commands,
// with results predicted by an in-bench contact table model and checked beat by beat.
// Depends on nkct_pkg and the name_keyed_contact_table RTL.
`timescale 1ns / 1ps

module name_keyed_contact_table_tb;

	localparam int unsigned TABLE_ENTRIES = 32;
	localparam int unsigned TEXT_BYTES    = 19;
	localparam int unsigned WATCHDOG_CYCLES = 300000;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned RANDOM_ITEMS  = 260;
	localparam logic [1:0]  MODE_UNKNOWN  = 2'd3;

	// Bytes beyond TEXT_BYTES are dropped before storing or comparing
	localparam logic [nkct_pkg::TEXT_MAX_W-1:0] TEXT_MASK = (TEXT_BYTES >= 19) ?
		{nkct_pkg::TEXT_MAX_W{1'b1}} : ((152'd1 << (8 * TEXT_BYTES)) - 152'd1);

	typedef struct {
		logic [1:0]                      mode;
		logic [nkct_pkg::TEXT_MAX_W-1:0] name;
		logic [nkct_pkg::TEXT_MAX_W-1:0] number;
	} contact_cmd_t;

	typedef struct {
		nkct_pkg::status_t               status;
		logic [nkct_pkg::TEXT_MAX_W-1:0] found;
		logic                            last;
	} contact_beat_t;

	// Contact table model plus queue of beats still owed by the block
	class contact_table_checker;
		logic [nkct_pkg::TEXT_MAX_W-1:0] stored_names[TABLE_ENTRIES];
		logic [nkct_pkg::TEXT_MAX_W-1:0] stored_numbers[TABLE_ENTRIES];
		int unsigned                     stored_count;
		contact_beat_t                   pending_beats[$];
		int unsigned                     error_count;

		function new();
			stored_count = 0;
			error_count  = 0;
		endfunction

		function void owe_beat(nkct_pkg::status_t st,
				logic [nkct_pkg::TEXT_MAX_W-1:0] txt, logic lst);
			contact_beat_t b;
			b.status = st;
			b.found  = txt;
			b.last   = lst;
			pending_beats.push_back(b);
		endfunction

		// Apply one accepted command to the model and queue its beats
		function void note_command(contact_cmd_t cmd);
			logic [nkct_pkg::TEXT_MAX_W-1:0] key;
			key = cmd.name & TEXT_MASK;
			case (cmd.mode)
			nkct_pkg::MODE_INSERT: begin
				if (stored_count >= TABLE_ENTRIES) begin
					owe_beat(nkct_pkg::STAT_FULL, '0, 1'b1);
				end else begin
					stored_names[stored_count]   = key;
					stored_numbers[stored_count] = cmd.number & TEXT_MASK;
					stored_count++;
					owe_beat(nkct_pkg::STAT_DONE, '0, 1'b1);
				end
			end
			nkct_pkg::MODE_SEARCH: begin
				for (int i = 0; i < stored_count; i++)
					if (stored_names[i] == key)
						owe_beat(nkct_pkg::STAT_MATCH, stored_numbers[i], 1'b0);
				owe_beat(nkct_pkg::STAT_DONE, '0, 1'b1);
			end
			nkct_pkg::MODE_DELETE: begin
				for (int i = 0; i < stored_count; i++)
					if (stored_names[i] == key) begin
						stored_names[i]   = nkct_pkg::REMOVED_TEXT & TEXT_MASK;
						stored_numbers[i] = nkct_pkg::REMOVED_TEXT & TEXT_MASK;
					end
				owe_beat(nkct_pkg::STAT_DONE, '0, 1'b1);
			end
			default: begin
				owe_beat(nkct_pkg::STAT_DONE, '0, 1'b1);
			end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			error_count++;
		endtask

		// Compare one result beat with the oldest owed beat
		task check_beat(logic [1:0] st, logic [63:0] lo, logic [63:0] mid,
				logic [23:0] hi, logic lst);
			contact_beat_t exp;
			if (pending_beats.size() == 0) begin
				report_mismatch("result beat with nothing pending");
				return;
			end
			exp = pending_beats.pop_front();
			if (st !== exp.status)
				report_mismatch($sformatf("status %0d, want %0d", st, exp.status));
			if (lo !== exp.found[63:0])
				report_mismatch($sformatf("found_low %h, want %h", lo, exp.found[63:0]));
			if (mid !== exp.found[127:64])
				report_mismatch($sformatf("found_mid %h, want %h", mid, exp.found[127:64]));
			if (hi !== exp.found[151:128])
				report_mismatch($sformatf("found_high %h, want %h", hi, exp.found[151:128]));
			if (lst !== exp.last)
				report_mismatch($sformatf("last %b, want %b", lst, exp.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [63:0] name_low;
	logic [63:0] name_mid;
	logic [23:0] name_high;
	logic [63:0] number_low;
	logic [63:0] number_mid;
	logic [23:0] number_high;
	logic        valid;
	logic [1:0]  status;
	logic [63:0] found_low;
	logic [63:0] found_mid;
	logic [23:0] found_high;
	logic        last;

	contact_table_checker            contacts = new();
	int unsigned                     idle_pct;
	int unsigned                     cycle_count;
	logic [nkct_pkg::TEXT_MAX_W-1:0] name_pool[8];

	name_keyed_contact_table #(
		.ENTRIES    (TABLE_ENTRIES),
		.TEXT_BYTES (TEXT_BYTES)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.name_low    (name_low),
		.name_mid    (name_mid),
		.name_high   (name_high),
		.number_low  (number_low),
		.number_mid  (number_mid),
		.number_high (number_high),
		.valid       (valid),
		.status      (status),
		.found_low   (found_low),
		.found_mid   (found_mid),
		.found_high  (found_high),
		.last        (last)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result beats are taken on the edge that ends their valid cycle
	always @(posedge clk) begin
		if (arst_n && valid)
			contacts.check_beat(status, found_low, found_mid, found_high, last);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= WATCHDOG_CYCLES) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [nkct_pkg::TEXT_MAX_W-1:0] random_text();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[nkct_pkg::TEXT_MAX_W-1:0];
	endfunction

	function automatic contact_cmd_t make_cmd(logic [1:0] m,
			logic [nkct_pkg::TEXT_MAX_W-1:0] nm,
			logic [nkct_pkg::TEXT_MAX_W-1:0] num);
		contact_cmd_t c;
		c.mode   = m;
		c.name   = nm;
		c.number = num;
		return c;
	endfunction

	// Hold start until the block takes the beat, then update the model
	task automatic send_command(contact_cmd_t cmd);
		int unsigned gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			// junk on the fields while start is low must be ignored
			start       <= 1'b0;
			mode        <= 2'($urandom);
			{name_high, name_mid, name_low}       <= random_text();
			{number_high, number_mid, number_low} <= random_text();
			repeat (gap) @(posedge clk);
		end
		mode <= cmd.mode;
		{name_high, name_mid, name_low}       <= cmd.name;
		{number_high, number_mid, number_low} <= cmd.number;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		contacts.note_command(cmd);
	endtask

	initial begin
		contact_cmd_t                    cmd;
		logic [nkct_pkg::TEXT_MAX_W-1:0] nm;
		int unsigned                     sel;

		cycle_count = 0;
		idle_pct    = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = nkct_pkg::MODE_INSERT;
		{name_high, name_mid, name_low}       = '0;
		{number_high, number_mid, number_low} = '0;

		// Pool of names so that random commands hit stored entries.
		// Entry 1 differs from entry 0 only in the top bit.
		name_pool[0] = random_text() & ~(152'd1 << 151);
		name_pool[1] = name_pool[0] | (152'd1 << 151);
		name_pool[2] = '0;
		name_pool[3] = {nkct_pkg::TEXT_MAX_W{1'b1}};
		name_pool[4] = nkct_pkg::REMOVED_TEXT;
		name_pool[5] = random_text();
		name_pool[6] = random_text();
		name_pool[7] = 152'h0065_6369_6C61;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, corner texts, duplicates, delete and removed marker
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[0], '0));
		send_command(make_cmd(nkct_pkg::MODE_DELETE, name_pool[0], '0));
		send_command(make_cmd(MODE_UNKNOWN, {nkct_pkg::TEXT_MAX_W{1'b1}},
			{nkct_pkg::TEXT_MAX_W{1'b1}}));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, '0, {nkct_pkg::TEXT_MAX_W{1'b1}}));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, {nkct_pkg::TEXT_MAX_W{1'b1}}, '0));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, name_pool[0], random_text()));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, name_pool[1], random_text()));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, name_pool[0], random_text()));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[0], '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[1], '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, '0, '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, {nkct_pkg::TEXT_MAX_W{1'b1}}, '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[5], '0));
		send_command(make_cmd(nkct_pkg::MODE_DELETE, name_pool[0], '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[0], '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, nkct_pkg::REMOVED_TEXT, '0));
		send_command(make_cmd(nkct_pkg::MODE_INSERT, nkct_pkg::REMOVED_TEXT,
			random_text()));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, nkct_pkg::REMOVED_TEXT, '0));
		send_command(make_cmd(MODE_UNKNOWN, name_pool[1], '0));
		send_command(make_cmd(nkct_pkg::MODE_DELETE, {nkct_pkg::TEXT_MAX_W{1'b1}}, '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, nkct_pkg::REMOVED_TEXT, '0));
		send_command(make_cmd(nkct_pkg::MODE_SEARCH, name_pool[1], '0));

		// Random: mostly pool names; the table fills and later inserts are refused
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n / 30) % 3)
			0: idle_pct = 0;
			1: idle_pct = 55;
			default: idle_pct = 31;
			endcase
			nm = ($urandom_range(99) < 85) ? name_pool[$urandom_range(7)] : random_text();
			sel = $urandom_range(99);
			if (sel < 35)
				cmd = make_cmd(nkct_pkg::MODE_INSERT, nm, random_text());
			else if (sel < 82)
				cmd = make_cmd(nkct_pkg::MODE_SEARCH, nm, random_text());
			else if (sel < 91)
				cmd = make_cmd(nkct_pkg::MODE_DELETE, nm, random_text());
			else
				cmd = make_cmd(MODE_UNKNOWN, nm, random_text());
			send_command(cmd);
		end
		start <= 1'b0;

		// Drain outstanding beats, then let the block settle
		while (contacts.pending_beats.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (contacts.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/nkct_pkg.sv
rtl/nkct_ctrl.sv
rtl/nkct_datapath.sv
rtl/name_keyed_contact_table.sv
sim/name_keyed_contact_table_tb.sv
